>>> design/dccps_pkg.sv
// dccps_pkg: shared types, codes and the frame symbol lookup for the DCC
// packet symbol sequencer. No dependencies.
`default_nettype none

package dccps_pkg;

  localparam logic [1:0] CmdTick        = 2'd0;
  localparam logic [1:0] CmdSubmitStd   = 2'd1;
  localparam logic [1:0] CmdSubmitExt   = 2'd2;
  localparam logic [1:0] CmdUnused      = 2'd3;

  localparam logic [1:0] SymZero   = 2'd0;
  localparam logic [1:0] SymOne    = 2'd1;
  localparam logic [1:0] SymCutout = 2'd2;

  localparam logic [7:0] RepeatCountReset = 8'd3;

  typedef struct packed {
    logic       ext;
    logic [7:0] third;
    logic [7:0] first;
    logic [7:0] addr;
  } packet_t;

  localparam packet_t IdlePacket = '{ext: 1'b0, third: 8'hFF, first: 8'h00, addr: 8'hFF};

  typedef struct packed {
    logic [1:0] cmd;
    logic       track;
    logic [7:0] address;
    logic [7:0] data_first;
    logic [7:0] data_second;
  } req_t;

  typedef struct packed {
    logic [1:0]  symbol;
    logic        symbol_valid;
    logic        frame_last;
    logic        sending_command;
    logic        sequence_done;
    logic        pending_overwritten;
    logic [15:0] commands_sent;
  } res_t;

  function automatic logic [1:0] bit_sym(input logic b);
    bit_sym = b ? SymOne : SymZero;
  endfunction

  // Symbol at offset q past the preamble (0..37).
  function automatic logic [1:0] symbol_at(input packet_t pkt, input logic [5:0] q);
    logic [2:0] k;
    logic [7:0] chk;
    logic [1:0] s;
    chk = pkt.addr ^ pkt.first ^ pkt.third;
    k = 3'd0;
    s = SymOne;
    if (q == 6'd0 || q == 6'd9 || q == 6'd18) begin
      s = SymZero;
    end else if (q <= 6'd8) begin
      k = 3'(q - 6'd1);
      s = bit_sym(pkt.addr[3'd7 - k]);
    end else if (q <= 6'd17) begin
      k = 3'(q - 6'd10);
      s = bit_sym(pkt.first[3'd7 - k]);
    end else if (q <= 6'd26) begin
      k = 3'(q - 6'd19);
      s = bit_sym(pkt.third[3'd7 - k]);
    end else if (q == 6'd27) begin
      s = pkt.ext ? SymZero : SymOne;
    end else if (q <= 6'd35) begin
      k = 3'(q - 6'd28);
      if (pkt.ext) begin
        s = bit_sym(chk[3'd7 - k]);
      end else begin
        s = (q == 6'd28) ? SymCutout : SymOne;
      end
    end else if (q == 6'd36) begin
      s = SymOne;
    end else begin
      s = pkt.ext ? SymCutout : SymOne;
    end
    symbol_at = s;
  endfunction

endpackage

`default_nettype wire

>>> design/dccps_if.sv
// dccps_if: request, result and configuration channel interfaces.
// Depends on nothing.
`default_nettype none

interface dccps_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       track;
  logic [7:0] address;
  logic [7:0] data_first;
  logic [7:0] data_second;
  modport source (output valid, cmd, track, address, data_first, data_second, input ready);
  modport sink   (input valid, cmd, track, address, data_first, data_second, output ready);
endinterface

interface dccps_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  symbol;
  logic        symbol_valid;
  logic        frame_last;
  logic        sending_command;
  logic        sequence_done;
  logic        pending_overwritten;
  logic [15:0] commands_sent;
  modport source (output valid, symbol, symbol_valid, frame_last, sending_command,
                  sequence_done, pending_overwritten, commands_sent, input ready);
  modport sink   (input valid, symbol, symbol_valid, frame_last, sending_command,
                  sequence_done, pending_overwritten, commands_sent, output ready);
endinterface

interface dccps_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> design/dccps_track.sv
// dccps_track: per-track frame position, waiting/active packet and counters.
// Depends on dccps_pkg.
`default_nettype none

module dccps_track #(
  parameter int PREAMBLE_LEN = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  strobe_i,
  input  dccps_pkg::req_t      req_i,
  input  wire  [7:0]           repeat_count_i,
  output dccps_pkg::res_t      res_o
);

  localparam int FrameLen = PREAMBLE_LEN + 38;
  localparam int PosW     = $clog2(FrameLen);

  logic [PosW-1:0]     pos_q, pos_d;
  dccps_pkg::packet_t  pend_q, pend_d;
  logic                pend_v_q, pend_v_d;
  dccps_pkg::packet_t  act_q, act_d;
  logic                act_cmd_q, act_cmd_d;
  logic [7:0]          rep_q, rep_d, rep_dec;
  logic [15:0]         cnt_q, cnt_d;
  logic                last;
  logic [5:0]          q_off;
  logic [1:0]          sym;

  assign last  = (pos_q == PosW'(FrameLen - 1));
  assign q_off = 6'(pos_q - PosW'(PREAMBLE_LEN));
  assign sym   = (pos_q < PosW'(PREAMBLE_LEN)) ? dccps_pkg::SymOne
                                               : dccps_pkg::symbol_at(act_q, q_off);
  assign rep_dec = (rep_q != 8'd0) ? rep_q - 8'd1 : 8'd0;

  always_comb begin
    pos_d     = pos_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    act_d     = act_q;
    act_cmd_d = act_cmd_q;
    rep_d     = rep_q;
    cnt_d     = cnt_q;
    res_o     = '0;
    res_o.sending_command = act_cmd_q;
    res_o.commands_sent   = cnt_q;
    case (req_i.cmd)
      dccps_pkg::CmdTick: begin
        res_o.symbol       = sym;
        res_o.symbol_valid = 1'b1;
        res_o.frame_last   = last;
        if (last) begin
          pos_d = '0;
          if (act_cmd_q) begin
            rep_d = rep_dec;
            if (rep_dec == 8'd0) begin
              act_cmd_d           = 1'b0;
              act_d               = dccps_pkg::IdlePacket;
              res_o.sequence_done = 1'b1;
            end
          end
          if (pend_v_q) begin
            act_d     = pend_q;
            act_cmd_d = 1'b1;
            rep_d     = (repeat_count_i != 8'd0) ? repeat_count_i : 8'd1;
            pend_v_d  = 1'b0;
          end
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
      dccps_pkg::CmdSubmitStd, dccps_pkg::CmdSubmitExt: begin
        res_o.pending_overwritten = pend_v_q;
        pend_d.addr  = req_i.address;
        pend_d.first = req_i.data_first;
        if (req_i.cmd == dccps_pkg::CmdSubmitStd) begin
          pend_d.third = req_i.address ^ req_i.data_first;
          pend_d.ext   = 1'b0;
        end else begin
          pend_d.third = req_i.data_second;
          pend_d.ext   = 1'b1;
        end
        pend_v_d = 1'b1;
        cnt_d    = cnt_q + 16'd1;
        res_o.commands_sent = cnt_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pend_v_q  <= 1'b0;
      act_q     <= dccps_pkg::IdlePacket;
      act_cmd_q <= 1'b0;
      rep_q     <= '0;
      cnt_q     <= '0;
    end else if (strobe_i) begin
      pos_q     <= pos_d;
      pend_v_q  <= pend_v_d;
      act_q     <= act_d;
      act_cmd_q <= act_cmd_d;
      rep_q     <= rep_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (strobe_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

>>> design/dcc_packet_symbol_sequencer_unit.sv
// dcc_packet_symbol_sequencer_unit: top level of the DCC symbol sequencer.
// Depends on dccps_pkg, dccps_if and dccps_track.
//
// Usage:
//   req_i  carries one request per accepted handshake: a symbol tick or a
//          packet submit for one track. res_o returns exactly one result per
//          request, in order. cfg_i writes repeat_count (always ready).
//   Path: a request is captured in the input register and resolved against
//          the track state into the result register, which offers it on
//          res_o.
//   Throughput: one request per cycle while res_o is not held off; the
//          track state update is a single pass of logic between the input
//          and result registers.
//   Stall: while res_o is held off the result register keeps its value; the
//          input register still takes one more request, then req_i.ready
//          drops until the result drains.
//   Reset: all tracks start at frame position zero sending idle packets,
//          nothing waiting, counters zero, repeat_count 3.
//   Requests to a track beyond TRACKS give an all-zero result.
`default_nettype none

module dcc_packet_symbol_sequencer_unit #(
  parameter int TRACKS       = 2,
  parameter int PREAMBLE_LEN = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  dccps_req_if.sink         req_i,
  dccps_res_if.source       res_o,
  dccps_cfg_if.sink         cfg_i
);

  logic              s0_valid_q;
  dccps_pkg::req_t   s0_q;
  logic              res_valid_q;
  dccps_pkg::res_t   res_q, res_d;
  logic [7:0]        repeat_count_q;
  logic              advance, go;
  logic [TRACKS-1:0] strobe;
  dccps_pkg::res_t   trk_res [TRACKS];

  assign advance     = !res_valid_q || res_o.ready;
  assign go          = s0_valid_q && advance;
  assign req_i.ready = !s0_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  for (genvar t = 0; t < TRACKS; t++) begin : g_track
    assign strobe[t] = go && (32'(s0_q.track) == t);
    dccps_track #(
      .PREAMBLE_LEN (PREAMBLE_LEN)
    ) u_track (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .strobe_i       (strobe[t]),
      .req_i          (s0_q),
      .repeat_count_i (repeat_count_q),
      .res_o          (trk_res[t])
    );
  end

  always_comb begin
    res_d = '0;
    for (int t = 0; t < TRACKS; t++) begin
      if (32'(s0_q.track) == t) begin
        res_d = trk_res[t];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q     <= 1'b0;
      res_valid_q    <= 1'b0;
      repeat_count_q <= dccps_pkg::RepeatCountReset;
    end else begin
      if (req_i.ready) begin
        s0_valid_q <= req_i.valid;
      end
      if (advance) begin
        res_valid_q <= s0_valid_q;
      end
      if (cfg_i.valid) begin
        repeat_count_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s0_q.cmd         <= req_i.cmd;
      s0_q.track       <= req_i.track;
      s0_q.address     <= req_i.address;
      s0_q.data_first  <= req_i.data_first;
      s0_q.data_second <= req_i.data_second;
    end
    if (go) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid               = res_valid_q;
  assign res_o.symbol              = res_q.symbol;
  assign res_o.symbol_valid        = res_q.symbol_valid;
  assign res_o.frame_last          = res_q.frame_last;
  assign res_o.sending_command     = res_q.sending_command;
  assign res_o.sequence_done       = res_q.sequence_done;
  assign res_o.pending_overwritten = res_q.pending_overwritten;
  assign res_o.commands_sent       = res_q.commands_sent;

  a_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && s0_valid_q) |-> go)
    else $error("request accepted into a full input register");

  a_go_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> res_valid_q)
    else $error("processed request produced no result");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.sequence_done) |-> (res_q.frame_last && res_q.symbol_valid))
    else $error("done pulse off the final frame symbol");

  a_overwrite_submit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.symbol_valid) |-> !res_q.pending_overwritten)
    else $error("overwrite flag on a tick result");

endmodule

`default_nettype wire

>>> sim/dcc_packet_symbol_sequencer_unit_test.sv
// Self-checking testbench for dcc_packet_symbol_sequencer_unit: directed table, then random
// request phases at several repeat_count settings, with a built-in symbol predictor.
// Depends on dccps_pkg, dccps_if and the sequencer RTL.
`timescale 1ns / 100ps

module dcc_packet_symbol_sequencer_unit_test;

  localparam int NumTracks   = 2;
  localparam int PreambleLen = 16;
  localparam int FrameLen    = PreambleLen + 38;
  localparam int PhaseItems  = 72;
  localparam int NumPhases   = 6;
  localparam int QuietLimit  = 3000;
  localparam int LongHold    = 60;

  typedef struct {
    dccps_pkg::req_t r;
    bit              typed;
    dccps_pkg::res_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dccps_req_if req_bus();
  dccps_res_if res_bus();
  dccps_cfg_if cfg_bus();

  dcc_packet_symbol_sequencer_unit #(
    .TRACKS      (NumTracks),
    .PREAMBLE_LEN(PreambleLen)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted track state
  logic [5:0]         frame_pos      [NumTracks];
  dccps_pkg::packet_t waiting_pkt    [NumTracks];
  logic               waiting        [NumTracks];
  dccps_pkg::packet_t on_air         [NumTracks];
  logic               on_air_cmd     [NumTracks];
  logic [7:0]         repeats_to_go  [NumTracks];
  logic [15:0]        submits        [NumTracks];
  logic [7:0]         repeat_setting;

  dccps_pkg::res_t results_due [$];
  dir_row_t        directed_rows [$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  results_seen = 0;
  int  frame_ends = 0;
  int  sequences_done = 0;
  int  overwrites = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  bit  steady_phase = 1'b0;
  bit  favored_track;
  int  repeat_plan [NumPhases];

  function automatic logic [1:0] frame_symbol_at(dccps_pkg::packet_t pkt, int pos);
    int q;
    logic [7:0] chk;
    chk = pkt.addr ^ pkt.first ^ pkt.third;
    q = pos - PreambleLen;
    if (pos < PreambleLen) return dccps_pkg::SymOne;
    if (q == 0 || q == 9 || q == 18) return dccps_pkg::SymZero;
    if (q <= 8) return pkt.addr[8 - q] ? dccps_pkg::SymOne : dccps_pkg::SymZero;
    if (q <= 17) return pkt.first[17 - q] ? dccps_pkg::SymOne : dccps_pkg::SymZero;
    if (q <= 26) return pkt.third[26 - q] ? dccps_pkg::SymOne : dccps_pkg::SymZero;
    if (q == 27) return pkt.ext ? dccps_pkg::SymZero : dccps_pkg::SymOne;
    if (q <= 35) begin
      if (pkt.ext) return chk[35 - q] ? dccps_pkg::SymOne : dccps_pkg::SymZero;
      return (q == 28) ? dccps_pkg::SymCutout : dccps_pkg::SymOne;
    end
    if (q == 36) return dccps_pkg::SymOne;
    return pkt.ext ? dccps_pkg::SymCutout : dccps_pkg::SymOne;
  endfunction

  function automatic void reset_tracks();
    for (int i = 0; i < NumTracks; i++) begin
      frame_pos[i]     = '0;
      waiting_pkt[i]   = '0;
      waiting[i]       = 1'b0;
      on_air[i]        = dccps_pkg::IdlePacket;
      on_air_cmd[i]    = 1'b0;
      repeats_to_go[i] = '0;
      submits[i]       = '0;
    end
    repeat_setting = dccps_pkg::RepeatCountReset;
  endfunction

  function automatic dccps_pkg::res_t predict_track_result(dccps_pkg::req_t r);
    dccps_pkg::res_t o;
    int p;
    int t;
    o = '0;
    t = r.track;
    case (r.cmd)
      dccps_pkg::CmdTick: begin
        p = frame_pos[t];
        if (p >= FrameLen) p = 0;
        o.symbol          = frame_symbol_at(on_air[t], p);
        o.symbol_valid    = 1'b1;
        o.frame_last      = (p + 1 >= FrameLen);
        o.sending_command = on_air_cmd[t];
        if (o.frame_last) begin
          frame_pos[t] = '0;
          if (on_air_cmd[t]) begin
            if (repeats_to_go[t] != 0) repeats_to_go[t] = repeats_to_go[t] - 8'd1;
            if (repeats_to_go[t] == 0) begin
              on_air_cmd[t]   = 1'b0;
              on_air[t]       = dccps_pkg::IdlePacket;
              o.sequence_done = 1'b1;
            end
          end
          if (waiting[t]) begin
            on_air[t]        = waiting_pkt[t];
            on_air_cmd[t]    = 1'b1;
            repeats_to_go[t] = (repeat_setting == 0) ? 8'd1 : repeat_setting;
            waiting[t]       = 1'b0;
          end
        end else begin
          frame_pos[t] = 6'(p + 1);
        end
        o.commands_sent = submits[t];
      end
      dccps_pkg::CmdUnused: begin
        o.sending_command = on_air_cmd[t];
        o.commands_sent   = submits[t];
      end
      default: begin
        o.pending_overwritten = waiting[t];
        if (r.cmd == dccps_pkg::CmdSubmitStd) begin
          waiting_pkt[t] = '{ext: 1'b0, third: r.address ^ r.data_first,
                             first: r.data_first, addr: r.address};
        end else begin
          waiting_pkt[t] = '{ext: 1'b1, third: r.data_second,
                             first: r.data_first, addr: r.address};
        end
        waiting[t]        = 1'b1;
        submits[t]        = submits[t] + 16'd1;
        o.sending_command = on_air_cmd[t];
        o.commands_sent   = submits[t];
      end
    endcase
    return o;
  endfunction

  function automatic dccps_pkg::req_t mk_req(logic [1:0] cmd, logic trk, logic [7:0] a,
                                             logic [7:0] f, logic [7:0] s);
    dccps_pkg::req_t r;
    r.cmd = cmd;
    r.track = trk;
    r.address = a;
    r.data_first = f;
    r.data_second = s;
    return r;
  endfunction

  function automatic dccps_pkg::res_t mk_res(logic [1:0] sym, logic sv, logic sc, logic ow,
                                             logic [15:0] cnt);
    dccps_pkg::res_t o;
    o = '0;
    o.symbol = sym;
    o.symbol_valid = sv;
    o.sending_command = sc;
    o.pending_overwritten = ow;
    o.commands_sent = cnt;
    return o;
  endfunction

  function automatic dccps_pkg::req_t random_request();
    dccps_pkg::req_t r;
    int n;
    n = $urandom_range(0, 99);
    if (n < 88)      r.cmd = dccps_pkg::CmdTick;
    else if (n < 94) r.cmd = dccps_pkg::CmdSubmitStd;
    else if (n < 98) r.cmd = dccps_pkg::CmdSubmitExt;
    else             r.cmd = dccps_pkg::CmdUnused;
    r.track       = ($urandom_range(0, 99) < 80) ? favored_track : !favored_track;
    r.address     = 8'($urandom);
    r.data_first  = 8'($urandom);
    r.data_second = 8'($urandom);
    return r;
  endfunction

  function automatic int idle_gap();
    int n;
    if (steady_phase) return 0;
    n = $urandom_range(0, 99);
    if (n < 60) return 0;
    if (n < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  task automatic offer_request(dccps_pkg::req_t r, bit typed, dccps_pkg::res_t want);
    dccps_pkg::res_t predicted;
    req_bus.valid       <= 1'b1;
    req_bus.cmd         <= r.cmd;
    req_bus.track       <= r.track;
    req_bus.address     <= r.address;
    req_bus.data_first  <= r.data_first;
    req_bus.data_second <= r.data_second;
    do @(posedge clk_i); while (!req_bus.ready);
    predicted = predict_track_result(r);
    results_due.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic pause_sender(int gap);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_repeat_count(logic [7:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    repeat_setting = value;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    dccps_pkg::res_t want;
    if (results_due.size() == 0) begin
      $display("%0t: result with no request outstanding, actual symbol %0h count %0h",
               $time, res_bus.symbol, res_bus.commands_sent);
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    results_seen++;
    compare_field("symbol", want.symbol, res_bus.symbol);
    compare_field("symbol_valid", want.symbol_valid, res_bus.symbol_valid);
    compare_field("frame_last", want.frame_last, res_bus.frame_last);
    compare_field("sending_command", want.sending_command, res_bus.sending_command);
    compare_field("sequence_done", want.sequence_done, res_bus.sequence_done);
    compare_field("pending_overwritten", want.pending_overwritten,
                  res_bus.pending_overwritten);
    compare_field("commands_sent", want.commands_sent, res_bus.commands_sent);
    if (res_bus.frame_last) frame_ends++;
    if (res_bus.sequence_done) sequences_done++;
    if (res_bus.pending_overwritten) overwrites++;
  endtask

  // result side: random stalls, one long hold-off to back up the request path
  initial begin
    res_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_bus.valid && res_bus.ready) begin
        check_result();
        if (results_seen == 150 && !long_hold_done) begin
          hold_left = LongHold;
          long_hold_done = 1'b1;
        end else if (hold_left == 0) begin
          hold_left = idle_gap();
        end
      end
      if (hold_left > 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, QuietLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_bus.valid       <= 1'b0;
    req_bus.cmd         <= dccps_pkg::CmdTick;
    req_bus.track       <= 1'b0;
    req_bus.address     <= '0;
    req_bus.data_first  <= '0;
    req_bus.data_second <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.data        <= '0;
    reset_tracks();

    repeat_plan = '{1, 0, 2, 255, 1, 1};
    repeat_plan[NumPhases - 1] = $urandom_range(1, 4);

    // reset state, extremes of the fields, every request kind, overwrite of a waiting packet
    directed_rows.push_back('{mk_req(dccps_pkg::CmdTick, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                              mk_res(dccps_pkg::SymOne, 1'b1, 1'b0, 1'b0, 16'd0)});
    directed_rows.push_back('{mk_req(dccps_pkg::CmdTick, 1'b1, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                              mk_res(dccps_pkg::SymOne, 1'b1, 1'b0, 1'b0, 16'd0)});
    directed_rows.push_back('{mk_req(dccps_pkg::CmdUnused, 1'b0, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                              mk_res(dccps_pkg::SymZero, 1'b0, 1'b0, 1'b0, 16'd0)});
    directed_rows.push_back('{mk_req(dccps_pkg::CmdSubmitStd, 1'b0, 8'hFF, 8'h00, 8'hFF), 1'b1,
                              mk_res(dccps_pkg::SymZero, 1'b0, 1'b0, 1'b0, 16'd1)});
    directed_rows.push_back('{mk_req(dccps_pkg::CmdSubmitStd, 1'b0, 8'h00, 8'hFF, 8'h00), 1'b1,
                              mk_res(dccps_pkg::SymZero, 1'b0, 1'b0, 1'b1, 16'd2)});
    directed_rows.push_back('{mk_req(dccps_pkg::CmdSubmitExt, 1'b1, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                              mk_res(dccps_pkg::SymZero, 1'b0, 1'b0, 1'b0, 16'd1)});
    directed_rows.push_back('{mk_req(dccps_pkg::CmdSubmitExt, 1'b1, 8'h00, 8'h00, 8'h80), 1'b1,
                              mk_res(dccps_pkg::SymZero, 1'b0, 1'b0, 1'b1, 16'd2)});
    directed_rows.push_back('{mk_req(dccps_pkg::CmdSubmitExt, 1'b1, 8'h80, 8'h01, 8'h7F), 1'b1,
                              mk_res(dccps_pkg::SymZero, 1'b0, 1'b0, 1'b1, 16'd3)});
    directed_rows.push_back('{mk_req(dccps_pkg::CmdUnused, 1'b1, 8'h00, 8'h00, 8'h00), 1'b1,
                              mk_res(dccps_pkg::SymZero, 1'b0, 1'b0, 1'b0, 16'd3)});
    for (int i = 0; i < 10; i++) begin
      directed_rows.push_back('{mk_req(dccps_pkg::CmdTick, 1'(i % 2), 8'(i), 8'(~i),
                                       8'(i * 37)), 1'b0, '0});
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_repeat_count(dccps_pkg::RepeatCountReset);
    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);
      pause_sender(idle_gap());
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      pause_sender(1);
      wait_drained();
      write_repeat_count(8'(repeat_plan[ph]));
      steady_phase  = (ph == 2 || ph == 4);
      favored_track = ph[0];
      for (int i = 0; i < PhaseItems; i++) begin
        offer_request(random_request(), 1'b0, '0);
        pause_sender(idle_gap());
      end
    end

    pause_sender(1);
    wait_drained();
    repeat (6) @(posedge clk_i);

    $display("Checked %0d results for %0d requests: %0d frame ends, %0d finished commands,",
             results_seen, requests_sent, frame_ends, sequences_done);
    $display("%0d overwritten submits, repeat_count settings 3, 1, 0, 2, 255, 1, %0d",
             overwrites, repeat_plan[NumPhases - 1]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/dccps_pkg.sv
design/dccps_if.sv
design/dccps_track.sv
design/dcc_packet_symbol_sequencer_unit.sv
sim/dcc_packet_symbol_sequencer_unit_test.sv
